### rtl/uks_pkg.sv
// ----------------------------------------------------------------------------
// uks_pkg
// Shared widths, request and status codes, and the control/status bundles
// between the controller and the datapath of the unique key stack.
// ----------------------------------------------------------------------------
package uks_pkg;

  localparam int KEY_W   = 31;
  localparam int PAY_W   = 16;
  localparam int REQ_W   = 2;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 5;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TOP    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic idle;    // ready to take a request word
    logic scan;    // walk the key memory
    logic top_rd;  // read the newest entry
    logic finish;  // build the result word and update the stack
  } uks_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             load;       // request word taken this cycle
    logic [REQ_W-1:0] req_type;   // type of the word being taken
    logic             fill_zero;  // stack holds no entries
    logic             scan_done;  // key scan finished or hit
    logic             out_free;   // result register can take a word
  } uks_stat_t;

endpackage

### rtl/uks_req_if.sv
// ----------------------------------------------------------------------------
// uks_req_if
// Request channel: valid/ready handshake with operation, key and payload.
// ----------------------------------------------------------------------------
interface uks_req_if
  import uks_pkg::*;
();

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [KEY_W-1:0] entry_key;
  logic [PAY_W-1:0] entry_payload;

  modport source (output valid, output req_type, output entry_key,
                  output entry_payload, input ready);
  modport sink   (input valid, input req_type, input entry_key,
                  input entry_payload, output ready);

endinterface

### rtl/uks_rsp_if.sv
// ----------------------------------------------------------------------------
// uks_rsp_if
// Result channel: valid/ready handshake with status, entry and fill level.
// ----------------------------------------------------------------------------
interface uks_rsp_if
  import uks_pkg::*;
();

  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [KEY_W-1:0]   out_key;
  logic [PAY_W-1:0]   out_payload;
  logic               is_empty;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, output status, output out_key, output out_payload,
                  output is_empty, output entry_count, input ready);
  modport sink   (input valid, input status, input out_key, input out_payload,
                  input is_empty, input entry_count, output ready);

endinterface

### rtl/unique_key_stack.sv
// ----------------------------------------------------------------------------
// unique_key_stack
// LIFO stack of key/payload entries with duplicate-key rejection and search.
// ----------------------------------------------------------------------------
// One request word is handled at a time. Push and search read the stored
// keys one per cycle from the single read port of the key memory, and stop
// early when the key is found; pop and top read the newest entry, and any
// request on an empty stack goes straight to the result word. A result word
// waiting in the output register does not block acceptance of the next
// request, only the finish of that request. entry_count reports the fill
// level in 5 bits.
// ----------------------------------------------------------------------------
module unique_key_stack
  import uks_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  uks_req_if.sink   req,
  uks_rsp_if.source rsp
);

  uks_cmd_t  cmd;
  uks_stat_t stat;

  uks_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  uks_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule

### rtl/uks_ctrl.sv
// ----------------------------------------------------------------------------
// uks_ctrl
// Sequencer for the unique key stack: takes one request word at a time,
// runs the key scan or the top read, then hands off the result word.
// ----------------------------------------------------------------------------
module uks_ctrl
  import uks_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  uks_stat_t stat,
  output uks_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_TOPRD = 5'b00100,
    S_DONE  = 5'b01000,
    S_SPARE = 5'b10000
  } state_t;

  state_t state, state_next;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (stat.load) begin
          if (stat.fill_zero) begin
            state_next = S_DONE;
          end else if (stat.req_type == REQ_PUSH || stat.req_type == REQ_SEARCH) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_TOPRD;
          end
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_DONE;
        end
      end
      S_TOPRD: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commands
  always_comb begin
    cmd.idle   = (state == S_IDLE);
    cmd.scan   = (state == S_SCAN);
    cmd.top_rd = (state == S_TOPRD);
    cmd.finish = (state == S_DONE) && stat.out_free;
  end

endmodule

### rtl/uks_dp.sv
// ----------------------------------------------------------------------------
// uks_dp
// Datapath of the unique key stack: request register, key and payload
// memories with one registered read port, scan counter and compare, fill
// level, and the result register.
// ----------------------------------------------------------------------------
module uks_dp
  import uks_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  uks_req_if.sink    req,
  uks_rsp_if.source  rsp,
  input  uks_cmd_t   cmd,
  output uks_stat_t  stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // Entry memories
  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [PAY_W-1:0] pay_mem [DEPTH];

  // Request register
  logic [REQ_W-1:0] req_q;
  logic [KEY_W-1:0] key_q;
  logic [PAY_W-1:0] pay_q;

  logic [CW-1:0]    fill;
  logic [CW-1:0]    fill_next;
  logic [CW-1:0]    issue_idx;
  logic             rd_pend;
  logic             hit;
  logic [PAY_W-1:0] hit_pay;
  logic [KEY_W-1:0] key_rd;
  logic [PAY_W-1:0] pay_rd;

  logic             load;
  logic             scan_issue;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             cmp_hit;
  logic             wr_en;

  // Result register
  logic               out_valid;
  logic [STAT_W-1:0]  out_status;
  logic [KEY_W-1:0]   out_key_q;
  logic [PAY_W-1:0]   out_pay_q;
  logic [COUNT_W-1:0] out_count;
  logic               out_empty;

  logic [STAT_W-1:0]  res_status;
  logic [KEY_W-1:0]   res_key;
  logic [PAY_W-1:0]   res_pay;
  logic [CW+COUNT_W-1:0] count_wide;

  assign req.ready = cmd.idle;
  assign load      = req.valid && cmd.idle;

  // Status to the controller
  always_comb begin
    stat.load      = load;
    stat.req_type  = req.req_type;
    stat.fill_zero = (fill == '0);
    stat.scan_done = hit || (!rd_pend && (issue_idx >= fill));
    stat.out_free  = !out_valid || rsp.ready;
  end

  // Capture the request word
  always_ff @(posedge clk) begin
    if (load) begin
      req_q <= req.req_type;
      key_q <= req.entry_key;
      pay_q <= req.entry_payload;
    end
  end

  // Read port: scan walks slots from the bottom, top read takes the newest
  assign scan_issue = cmd.scan && !hit && (issue_idx < fill);
  assign rd_en      = scan_issue || cmd.top_rd;
  assign rd_addr    = cmd.top_rd ? AW'(fill - 1'b1) : issue_idx[AW-1:0];
  assign cmp_hit    = rd_pend && (key_rd == key_q);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      key_rd <= key_mem[rd_addr];
      pay_rd <= pay_mem[rd_addr];
    end
    if (wr_en) begin
      key_mem[fill[AW-1:0]] <= key_q;
      pay_mem[fill[AW-1:0]] <= pay_q;
    end
  end

  // Scan counter, pending compare and hit flag
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_idx <= '0;
      rd_pend   <= 1'b0;
      hit       <= 1'b0;
    end else begin
      rd_pend <= scan_issue;
      if (load) begin
        issue_idx <= '0;
        hit       <= 1'b0;
      end else begin
        if (scan_issue) begin
          issue_idx <= issue_idx + 1'b1;
        end
        if (cmp_hit) begin
          hit <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_hit) begin
      hit_pay <= pay_rd;
    end
  end

  // Result word and stack update
  always_comb begin
    res_status = ST_OK;
    res_key    = '0;
    res_pay    = '0;
    fill_next  = fill;
    wr_en      = 1'b0;
    unique case (req_q)
      REQ_PUSH: begin
        if (hit) begin
          res_status = ST_DUP;
        end else if (fill >= DEPTH_C) begin
          res_status = ST_FULL;
        end else begin
          wr_en     = cmd.finish;
          fill_next = fill + 1'b1;
        end
      end
      REQ_POP, REQ_TOP: begin
        if (fill == '0) begin
          res_status = ST_EMPTY;
        end else begin
          res_key = key_rd;
          res_pay = pay_rd;
          if (req_q == REQ_POP) begin
            fill_next = fill - 1'b1;
          end
        end
      end
      REQ_SEARCH: begin
        if (hit) begin
          res_key = key_q;
          res_pay = hit_pay;
        end else begin
          res_status = ST_NOTFOUND;
        end
      end
    endcase
    count_wide = {{COUNT_W{1'b0}}, fill_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.finish) begin
      fill <= fill_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status <= res_status;
      out_key_q  <= res_key;
      out_pay_q  <= res_pay;
      out_empty  <= (fill_next == '0);
      out_count  <= count_wide[COUNT_W-1:0];
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.out_key     = out_key_q;
  assign rsp.out_payload = out_pay_q;
  assign rsp.is_empty    = out_empty;
  assign rsp.entry_count = out_count;

endmodule
